// ===== rtl/hcb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared constants and types of the Hill cipher block encryptor.
// ----------------------------------------------------------------------------
package hcb_pkg;

   localparam int MAX_BLOCK  = 3;
   localparam int CODE_W     = 5;
   localparam int GAP_W      = 8;
   localparam int CHAR_W     = 8;
   localparam int KEY_W      = 15;
   localparam int SIZE_W     = 2;
   localparam int REG_IDX_W  = 2;
   localparam int RES_CNT_W  = 2;
   localparam int GRP_DEPTH  = 4;
   localparam int GRP_PTR_W  = $clog2(GRP_DEPTH);
   localparam int GRP_CNT_W  = $clog2(GRP_DEPTH + 1);

   localparam logic [CHAR_W-1:0] LETTER_A   = 8'd97;
   localparam logic [CHAR_W-1:0] ALPHA      = 8'd26;
   localparam logic [CHAR_W-1:0] LETTER_END = LETTER_A + ALPHA;
   localparam logic [CODE_W-1:0] PAD_CODE   = 5'(ALPHA - 8'd1);
   localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'd32;
   localparam logic [GAP_W-1:0]  GAP_MAX    = {GAP_W{1'b1}};

   localparam logic [REG_IDX_W-1:0] REG_BLOCK_SIZE = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_KEY_ROW0   = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_KEY_ROW1   = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_KEY_ROW2   = 2'd3;

   typedef logic [CODE_W-1:0] code_type;

   typedef struct packed {
      logic [CHAR_W-1:0] cipher_char;
      logic              letter_valid;
      logic [GAP_W-1:0]  spaces_before;
      logic              run_last;
      logic              text_done;
   } rsp_item_type;

   typedef struct packed {
      logic [RES_CNT_W-1:0]                count;
      rsp_item_type [MAX_BLOCK-1:0]        item;
   } rsp_group_type;

endpackage

// ===== rtl/hcb_intf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_intf
// Valid/ready channels for text input, cipher results and register writes.
// ----------------------------------------------------------------------------
interface hcb_req_if
   import hcb_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] text_byte;
   logic              end_of_text;

   modport source (output valid, text_byte, end_of_text, input ready);
   modport sink (input valid, text_byte, end_of_text, output ready);
endinterface

interface hcb_rsp_if
   import hcb_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] cipher_char;
   logic              letter_valid;
   logic [GAP_W-1:0]  spaces_before;
   logic              run_last;
   logic              text_done;

   modport source (output valid, cipher_char, letter_valid, spaces_before, run_last,
      text_done, input ready);
   modport sink (input valid, cipher_char, letter_valid, spaces_before, run_last,
      text_done, output ready);
endinterface

interface hcb_csr_if
   import hcb_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [REG_IDX_W-1:0] index;
   logic [KEY_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/hcb_mixer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_mixer
// Key matrix times letter vector, modulo 26, for blocks of two or three.
// ----------------------------------------------------------------------------
module hcb_mixer
   import hcb_pkg::*;
(
   input  logic [MAX_BLOCK-1:0][KEY_W-1:0] key_rows,
   input  code_type [MAX_BLOCK-1:0]        letters,
   input  logic                            three,
   output code_type [MAX_BLOCK-1:0]        cipher
);

   localparam int SUM_W = 12;
   localparam int PROD_W = 2 * CODE_W;

   // Floor of x / 26 is taken as (x * 2520) >> 16, which is low by at most one.
   function automatic code_type mod_alpha(input logic [SUM_W-1:0] x);
      logic [2*SUM_W-1:0] prod;
      logic [7:0]         quot;
      logic [SUM_W-1:0]   qm;
      logic [SUM_W-1:0]   rem;
      prod = {{SUM_W{1'b0}}, x} * 24'd2520;
      quot = prod[23:16];
      qm   = {4'd0, quot} * 12'(ALPHA);
      rem  = x - qm;
      if (rem >= 12'(ALPHA)) begin
         rem = rem - 12'(ALPHA);
      end
      return rem[CODE_W-1:0];
   endfunction

   logic [MAX_BLOCK-1:0][SUM_W-1:0] row_sum;

   always_comb begin
      for (int i = 0; i < MAX_BLOCK; i++) begin
         row_sum[i] = '0;
         for (int j = 0; j < MAX_BLOCK; j++) begin
            if (j < MAX_BLOCK - 1 || three) begin
               row_sum[i] = row_sum[i] + SUM_W'(PROD_W'(key_rows[i][CODE_W*j +: CODE_W])
                  * PROD_W'(letters[j]));
            end
         end
         cipher[i] = mod_alpha(row_sum[i]);
      end
   end

endmodule

// ===== rtl/hcb_result_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_result_queue
// Queue of result groups, drained one result beat per cycle while rsp.ready is high.
// ----------------------------------------------------------------------------
module hcb_result_queue
   import hcb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  rsp_group_type push_group,
   output logic          room,
   hcb_rsp_if.source     rsp
);

   rsp_group_type        grp_ff [GRP_DEPTH];
   logic [GRP_PTR_W-1:0] wr_ff, wr_in;
   logic [GRP_PTR_W-1:0] rd_ff, rd_in;
   logic [GRP_CNT_W-1:0] count_ff, count_in;
   logic [RES_CNT_W-1:0] sub_ff, sub_in;
   rsp_group_type        head;
   rsp_item_type         head_item;
   logic                 pop;
   logic                 pop_group;

   assign head      = grp_ff[rd_ff];
   assign head_item = head.item[sub_ff];
   assign room      = (count_ff != GRP_CNT_W'(GRP_DEPTH));

   assign rsp.valid         = (count_ff != '0);
   assign rsp.cipher_char   = head_item.cipher_char;
   assign rsp.letter_valid  = head_item.letter_valid;
   assign rsp.spaces_before = head_item.spaces_before;
   assign rsp.run_last      = head_item.run_last;
   assign rsp.text_done     = head_item.text_done;

   always_comb begin
      pop       = rsp.valid && rsp.ready;
      pop_group = pop && (sub_ff == head.count - RES_CNT_W'(1));
      wr_in     = push ? wr_ff + GRP_PTR_W'(1) : wr_ff;
      rd_in     = pop_group ? rd_ff + GRP_PTR_W'(1) : rd_ff;
      sub_in    = pop_group ? '0 : (pop ? sub_ff + RES_CNT_W'(1) : sub_ff);
      count_in  = count_ff + GRP_CNT_W'(push) - GRP_CNT_W'(pop_group);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         sub_ff   <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         sub_ff   <= sub_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         grp_ff[wr_ff] <= push_group;
      end
   end

endmodule

// ===== rtl/hcb_blocker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_blocker
// Input register, letter gathering and padding, and result group assembly.
// ----------------------------------------------------------------------------
module hcb_blocker
   import hcb_pkg::*;
(
   input  logic                            clock,
   input  logic                            reset,
   hcb_req_if.sink                         req,
   input  logic [SIZE_W-1:0]               block_size,
   input  logic [MAX_BLOCK-1:0][KEY_W-1:0] key_rows,
   input  logic                            room,
   output logic                            push,
   output rsp_group_type                   push_group
);

   logic                         in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0]            in_byte_ff;
   logic                         in_end_ff;
   code_type [MAX_BLOCK-1:0]     letter_ff, letter_a;
   logic [MAX_BLOCK-1:0][GAP_W-1:0] gap_ff, gap_in, gap_a, blk_gap;
   logic [RES_CNT_W-1:0]         fill_ff, fill_in, fill_a, fill_b, slot;
   logic [GAP_W-1:0]             pend_ff, pend_in, pend_a, pend_b;
   code_type [MAX_BLOCK-1:0]     blk_letter, cipher;
   logic                         three, is_letter, letter_blk, end_blk, emit, space;
   logic                         pad, advance;
   logic [RES_CNT_W-1:0]         nsize, space_idx, last_idx;
   logic [RES_CNT_W:0]           cnt_wide;

   hcb_mixer u_mixer (
      .key_rows (key_rows),
      .letters  (blk_letter),
      .three    (three),
      .cipher   (cipher)
   );

   always_comb begin
      three     = (block_size == 2'd3);
      nsize     = three ? 2'd3 : 2'd2;
      is_letter = (in_byte_ff >= LETTER_A) && (in_byte_ff < LETTER_END);
      slot      = (fill_ff == 2'd3) ? 2'd2 : fill_ff;
      letter_a  = letter_ff;
      gap_a     = gap_ff;
      if (is_letter) begin
         letter_a[slot] = CODE_W'(in_byte_ff - LETTER_A);
         gap_a[slot]    = pend_ff;
         pend_a         = '0;
         fill_a         = slot + 2'd1;
      end else begin
         pend_a = (pend_ff != GAP_MAX) ? pend_ff + GAP_W'(1) : pend_ff;
         fill_a = fill_ff;
      end
      letter_blk = is_letter && (fill_a >= nsize);
      fill_b     = letter_blk ? '0 : fill_a;
      end_blk    = in_end_ff && (fill_b != '0);
      emit       = letter_blk || end_blk;

      // At end of text a partial block is filled with z; the first pad takes the gap.
      for (int j = 0; j < MAX_BLOCK; j++) begin
         pad = end_blk && (RES_CNT_W'(j) >= fill_b) && (RES_CNT_W'(j) < nsize);
         blk_letter[j] = pad ? PAD_CODE : letter_a[j];
         blk_gap[j]    = pad ? ((RES_CNT_W'(j) == fill_b) ? pend_a : '0) : gap_a[j];
      end
      pend_b = (end_blk && (fill_b < nsize)) ? '0 : pend_a;
      space  = in_end_ff && (pend_b != '0);

      cnt_wide  = (emit ? {1'b0, nsize} : '0) + (RES_CNT_W+1)'(space);
      space_idx = emit ? nsize : '0;
      last_idx  = cnt_wide[RES_CNT_W-1:0] - RES_CNT_W'(1);

      push_group.count = cnt_wide[RES_CNT_W-1:0];
      for (int j = 0; j < MAX_BLOCK; j++) begin
         push_group.item[j].cipher_char   = LETTER_A + CHAR_W'(cipher[j]);
         push_group.item[j].letter_valid  = 1'b1;
         push_group.item[j].spaces_before = blk_gap[j];
         push_group.item[j].run_last      = 1'b0;
         push_group.item[j].text_done     = 1'b0;
      end
      if (space && (space_idx < RES_CNT_W'(MAX_BLOCK))) begin
         push_group.item[space_idx].cipher_char   = SPACE_CHAR;
         push_group.item[space_idx].letter_valid  = 1'b0;
         push_group.item[space_idx].spaces_before = pend_b;
      end
      if (cnt_wide != '0) begin
         push_group.item[last_idx].run_last  = 1'b1;
         push_group.item[last_idx].text_done = in_end_ff;
      end

      advance     = in_valid_ff && (room || (cnt_wide == '0));
      push        = advance && (cnt_wide != '0);
      req.ready   = !in_valid_ff || advance;
      in_valid_in = (req.valid && req.ready) ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

      gap_in  = in_end_ff ? '0 : gap_a;
      fill_in = in_end_ff ? '0 : fill_b;
      pend_in = in_end_ff ? '0 : pend_a;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         gap_ff      <= '0;
         fill_ff     <= '0;
         pend_ff     <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            gap_ff  <= gap_in;
            fill_ff <= fill_in;
            pend_ff <= pend_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff <= req.text_byte;
         in_end_ff  <= req.end_of_text;
      end
      if (advance) begin
         letter_ff <= letter_a;
      end
   end

endmodule

// ===== rtl/hill_cipher_block_encrypt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hill_cipher_block_encrypt
// Hill cipher encryptor over a byte stream, blocks of two or three letters.
// ----------------------------------------------------------------------------
// Each input byte is registered in the blocker; its result group is then written
// into the queue. Throughput: one input beat per cycle and, while rsp_ch is ready,
// one result beat per cycle; a block of n letters yields n result beats, buffered
// in a queue of four result groups. Input stalls only while that queue is full.
// Reset is synchronous and active high: block size 2, key rows zero, queue empty.
module hill_cipher_block_encrypt
   import hcb_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   hcb_req_if.sink   req_ch,
   hcb_rsp_if.source rsp_ch,
   hcb_csr_if.sink   csr_ch
);

   logic [SIZE_W-1:0]               block_size_ff;
   logic [MAX_BLOCK-1:0][KEY_W-1:0] key_row_ff;
   logic                            push;
   logic                            room;
   rsp_group_type                   push_group;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff <= 2'd2;
         key_row_ff    <= '0;
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            REG_BLOCK_SIZE: block_size_ff <= csr_ch.data[SIZE_W-1:0];
            REG_KEY_ROW0:   key_row_ff[0] <= csr_ch.data;
            REG_KEY_ROW1:   key_row_ff[1] <= csr_ch.data;
            REG_KEY_ROW2:   key_row_ff[2] <= csr_ch.data;
            default:        block_size_ff <= block_size_ff;
         endcase
      end
   end

   hcb_blocker u_blocker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .block_size (block_size_ff),
      .key_rows   (key_row_ff),
      .room       (room),
      .push       (push),
      .push_group (push_group)
   );

   hcb_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (push_group),
      .room       (room),
      .rsp        (rsp_ch)
   );

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.text_done |-> rsp_ch.run_last)
      else $error("text_done without run_last");

   a_space_form: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.letter_valid |-> rsp_ch.cipher_char == SPACE_CHAR
         && rsp_ch.spaces_before != '0 && rsp_ch.text_done)
      else $error("malformed letter-free result");

   a_letter_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.letter_valid |-> rsp_ch.cipher_char >= LETTER_A
         && rsp_ch.cipher_char < LETTER_END)
      else $error("cipher letter out of range");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid right after reset");

endmodule
